// ===== rtl/slr_pkg.sv =====
// shared types and constants for the multichannel motor slew limiter
// used by slr_step_unit and multichannel_motor_slew_limiter
`timescale 1ns / 1ps

package slr_pkg;

    localparam int CH_W         = 4;
    localparam int SPEED_W      = 8;
    localparam int REQ_W        = 10;
    localparam int STEP_W       = 7;
    localparam int CHANNELS_DEF = 10;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 8'sd127;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN  = -8'sd127;
    localparam logic [STEP_W-1:0]         STEP_RESET = 7'd10;

    // input item kinds carried on s_tuser
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target;
        logic signed [SPEED_W-1:0] current;
        logic                      slewing;
    } chan_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] current;
        logic                      slewing;
    } chan_upd_t;

    // saturate a request speed to the legal drive range
    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [REQ_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > REQ_W'(SPEED_MAX)) begin
            r = SPEED_MAX;
        end else if (v < REQ_W'(SPEED_MIN)) begin
            r = SPEED_MIN;
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/slr_step_unit.sv =====
// shared add/compare unit: one slew step for one channel
// depends on slr_pkg
`timescale 1ns / 1ps

module slr_step_unit (
    input  slr_pkg::chan_t                     chan_in,
    input  logic [slr_pkg::STEP_W-1:0]         step,
    output slr_pkg::chan_upd_t                 chan_out
);
    import slr_pkg::*;

    localparam int EXT_W = SPEED_W + 2;

    logic signed [EXT_W-1:0] tgt_ext;
    logic signed [EXT_W-1:0] cur_ext;
    logic signed [EXT_W-1:0] step_ext;
    logic signed [EXT_W-1:0] up_val;
    logic signed [EXT_W-1:0] dn_val;

    assign tgt_ext  = EXT_W'(chan_in.target);
    assign cur_ext  = EXT_W'(chan_in.current);
    assign step_ext = $signed({{(EXT_W-STEP_W){1'b0}}, step});
    assign up_val   = cur_ext + step_ext;
    assign dn_val   = cur_ext - step_ext;

    always_comb begin
        chan_out.current = chan_in.current;
        chan_out.slewing = chan_in.slewing;
        if (chan_in.slewing) begin
            if (tgt_ext > cur_ext) begin
                if (up_val > tgt_ext) begin
                    chan_out.current = chan_in.target;
                    chan_out.slewing = 1'b0;
                end else begin
                    chan_out.current = up_val[SPEED_W-1:0];
                end
            end else if (tgt_ext < cur_ext) begin
                if (dn_val < tgt_ext) begin
                    chan_out.current = chan_in.target;
                    chan_out.slewing = 1'b0;
                end else begin
                    chan_out.current = dn_val[SPEED_W-1:0];
                end
            end else begin
                chan_out.slewing = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/multichannel_motor_slew_limiter.sv =====
// Multichannel motor slew limiter, top level.
// Channels: s_ stream takes requests and ticks; s_tuser is the kind
// (0 = speed request, 1 = tick). A request stores a clamped target speed
// for channel 1..CHANNELS and starts slewing it; other channel numbers are
// dropped. A request gives no result.
// A tick visits the channels in order, one channel per cycle through the
// shared step unit while the result register is free, and sends one m_
// transfer per channel with m_tlast on the final one. Accepting the tick
// moves the state register to run; each result is then registered from
// the step unit. The walk is paced by the one read-modify-write port into
// the per-channel registers.
// s_tready is low while a tick is being walked. When the receiver stalls,
// the result register holds and the walk waits on it.
// cfg_we writes slew_step from cfg_wdata; write it only while idle.
// Reset (aresetn low, synchronous) zeroes all speeds and flags, sets
// slew_step to 10 and empties the result register.
`timescale 1ns / 1ps

module multichannel_motor_slew_limiter #(
    parameter int CHANNELS = slr_pkg::CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // channel[3:0], requested_speed[13:4]
    input  logic                          s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // out_channel[3:0], drive_speed[11:4]
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [slr_pkg::STEP_W-1:0]    cfg_wdata
);
    import slr_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      state_reg, state_next;
    logic [IDX_W-1:0]          cnt_reg;
    logic [STEP_W-1:0]         slew_step_reg;
    logic signed [SPEED_W-1:0] target_reg  [CHANNELS];
    logic signed [SPEED_W-1:0] current_reg [CHANNELS];
    logic [CHANNELS-1:0]       slewing_reg;

    logic                      m_tvalid_reg;
    logic [15:0]               m_tdata_reg;
    logic                      m_tlast_reg;

    logic [CH_W-1:0]           req_ch;
    logic signed [REQ_W-1:0]   req_speed;
    logic                      req_ok;
    logic [IDX_W-1:0]          req_idx;
    logic                      s_xfer;
    logic                      do_req;
    logic                      do_tick;
    logic                      out_free;
    logic                      step_en;
    logic                      at_last;
    logic [CH_W-1:0]           ch_num;

    chan_t                     unit_in;
    chan_upd_t                 unit_out;

    assign req_ch    = s_tdata[CH_W-1:0];
    assign req_speed = $signed(s_tdata[CH_W+REQ_W-1:CH_W]);
    assign req_ok    = (req_ch != '0) && ({1'b0, req_ch} <= (CH_W+1)'(CHANNELS));
    assign req_idx   = IDX_W'(req_ch - CH_W'(1));

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign do_req    = s_xfer && (s_tuser == OP_REQUEST) && req_ok;
    assign do_tick   = s_xfer && (s_tuser == OP_TICK);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign step_en   = (state_reg == ST_RUN) && out_free;
    assign at_last   = (cnt_reg == IDX_W'(CHANNELS - 1));
    // channel 16 wraps to 0 in the 4-bit field
    assign ch_num    = CH_W'(cnt_reg) + CH_W'(1);

    assign unit_in.target  = target_reg[cnt_reg];
    assign unit_in.current = current_reg[cnt_reg];
    assign unit_in.slewing = slewing_reg[cnt_reg];

    slr_step_unit u_step (
        .chan_in  (unit_in),
        .step     (slew_step_reg),
        .chan_out (unit_out)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (do_tick) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_en && at_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            slew_step_reg <= STEP_RESET;
            slewing_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                target_reg[i]  <= '0;
                current_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                slew_step_reg <= cfg_wdata;
            end
            if (do_tick) begin
                cnt_reg <= '0;
            end
            if (do_req) begin
                target_reg[req_idx]  <= clamp_speed(req_speed);
                slewing_reg[req_idx] <= 1'b1;
            end
            // one channel per cycle through the step unit, while the result register is free
            if (step_en) begin
                current_reg[cnt_reg] <= unit_out.current;
                slewing_reg[cnt_reg] <= unit_out.slewing;
                m_tvalid_reg         <= 1'b1;
                cnt_reg              <= cnt_reg + IDX_W'(1);
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_tdata_reg <= {4'b0000, unit_out.current, ch_num};
            m_tlast_reg <= at_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== sim/multichannel_motor_slew_limiter_test.sv =====
// self-checking testbench for multichannel_motor_slew_limiter
// predicts every per-channel speed report of a tick and compares it with the m_ stream
// depends on rtl/slr_pkg.sv and rtl/multichannel_motor_slew_limiter.sv
`timescale 1ns / 1ps

module multichannel_motor_slew_limiter_test;
    import slr_pkg::*;

    localparam int CHANNELS  = CHANNELS_DEF;
    localparam int MAX_CYCLES = 500000;

    typedef struct packed {
        logic [CH_W-1:0]           chan;
        logic signed [SPEED_W-1:0] speed;
        logic                      last;
    } speed_report_t;

    // tracks the per-channel speeds and holds the speed reports still owed by the block
    class speed_predictor;
        logic signed [SPEED_W-1:0] target_speed[CHANNELS];
        logic signed [SPEED_W-1:0] drive_speed[CHANNELS];
        bit                        slewing[CHANNELS];
        logic [STEP_W-1:0]         step;
        speed_report_t             owed_reports[$];
        int                        errors;

        function new();
            for (int k = 0; k < CHANNELS; k++) begin
                target_speed[k] = '0;
                drive_speed[k]  = '0;
                slewing[k]      = 1'b0;
            end
            step   = STEP_RESET;
            errors = 0;
        endfunction

        function void set_step(logic [STEP_W-1:0] v);
            step = v;
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        // called for every accepted s_ transfer
        function void note_transfer(logic op, logic [CH_W-1:0] ch,
                                    logic signed [REQ_W-1:0] req);
            int            want;
            int            tgt;
            int            cur;
            speed_report_t rep;
            if (op == OP_REQUEST) begin
                if (ch == 0 || ch > CHANNELS) return;
                want = req;
                if (want > 127) want = 127;
                if (want < -127) want = -127;
                target_speed[ch-1] = want[SPEED_W-1:0];
                slewing[ch-1]      = 1'b1;
                return;
            end
            for (int k = 0; k < CHANNELS; k++) begin
                tgt = target_speed[k];
                cur = drive_speed[k];
                if (slewing[k]) begin
                    if (tgt > cur) begin
                        cur += int'(step);
                        if (cur > tgt) begin
                            cur = tgt;
                            slewing[k] = 1'b0;
                        end
                    end else if (tgt < cur) begin
                        cur -= int'(step);
                        if (cur < tgt) begin
                            cur = tgt;
                            slewing[k] = 1'b0;
                        end
                    end else begin
                        slewing[k] = 1'b0;
                    end
                    drive_speed[k] = cur[SPEED_W-1:0];
                end
                rep.chan  = CH_W'(k + 1);
                rep.speed = drive_speed[k];
                rep.last  = (k == CHANNELS - 1);
                owed_reports.push_back(rep);
            end
        endfunction

        // called for every accepted m_ transfer
        function void check_report(logic [15:0] data, logic last);
            speed_report_t got;
            speed_report_t exp_rep;
            got.chan  = data[CH_W-1:0];
            got.speed = data[CH_W+SPEED_W-1:CH_W];
            got.last  = last;
            if (owed_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report ch %0d speed %0d last %0b", $realtime,
                         got.chan, got.speed, got.last);
                return;
            end
            exp_rep = owed_reports.pop_front();
            if (got !== exp_rep) begin
                errors++;
                $display("%0t: expected ch %0d speed %0d last %0b, got ch %0d speed %0d last %0b",
                         $realtime, exp_rep.chan, exp_rep.speed, exp_rep.last,
                         got.chan, got.speed, got.last);
            end
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic              s_tuser   = OP_REQUEST;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    logic [STEP_W-1:0] cfg_wdata = '0;

    speed_predictor predictor = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    multichannel_motor_slew_limiter #(
        .CHANNELS(CHANNELS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: values read right after the edge are the pre-edge ones
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
                predictor.check_report(m_tdata, m_tlast);
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // leaves s_tvalid high after the transfer so back-to-back items need no toggle
    task automatic send_item(logic op, logic [CH_W-1:0] ch, logic signed [REQ_W-1:0] req);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, req, ch};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predictor.note_transfer(op, ch, req);
    endtask

    task automatic idle_gap();
        int n;
        n = 0;
        while ($urandom_range(99) < tx_idle_pct && n < 200) n++;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (predictor.pending() != 0) @(posedge aclk);
    endtask

    // slew_step may only change while the block is idle
    task automatic write_step(logic [STEP_W-1:0] v);
        drain_reports();
        repeat (CHANNELS + 4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        predictor.set_step(v);
    endtask

    task automatic send_random(int count, int tick_pct);
        logic                    op;
        logic [CH_W-1:0]         ch;
        logic signed [REQ_W-1:0] req;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_REQUEST;
            if ($urandom_range(99) < 85) begin
                ch = CH_W'($urandom_range(1, CHANNELS));
            end else begin
                // out-of-range channels, including zero
                ch = CH_W'($urandom_range(0, 15 - CHANNELS));
                if (ch != 0) ch = ch + CH_W'(CHANNELS);
            end
            case ($urandom_range(3))
                0: req = REQ_W'($urandom_range(0, 254)) - REQ_W'(127);
                1: begin
                    // just around the clamp limits
                    req = REQ_W'($urandom_range(120, 135));
                    if ($urandom_range(1)) req = -req;
                end
                default: req = REQ_W'($urandom_range(0, 1023));
            endcase
            send_item(op, ch, req);
            idle_gap();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed part at the reset step of 10
        send_item(OP_REQUEST, 4'd1, 10'sd511);     // clamps to 127
        send_item(OP_REQUEST, 4'd2, -10'sd512);    // clamps to -127
        send_item(OP_REQUEST, 4'd3, 10'sd127);
        send_item(OP_REQUEST, 4'd4, -10'sd127);
        send_item(OP_REQUEST, 4'd5, 10'sd128);
        send_item(OP_REQUEST, 4'd6, -10'sd128);
        send_item(OP_REQUEST, 4'd7, 10'sd20);      // lands exactly after two ticks
        send_item(OP_REQUEST, 4'd8, 10'sd0);       // already at target
        send_item(OP_REQUEST, 4'd10, 10'sd5);      // overshoot on the first tick
        send_item(OP_REQUEST, 4'd0, 10'sd100);     // ignored
        send_item(OP_REQUEST, 4'd11, 10'sd1);      // ignored
        send_item(OP_REQUEST, 4'd15, -10'sd50);    // ignored
        send_item(OP_TICK, 4'd9, 10'sd0);
        send_item(OP_TICK, 4'd0, -10'sd1);
        send_item(OP_TICK, 4'd15, 10'sd511);
        send_item(OP_REQUEST, 4'd1, -10'sd3);      // reverse direction mid-slew
        send_item(OP_TICK, 4'd5, 10'sd0);
        send_item(OP_TICK, 4'd5, 10'sd0);

        write_step(7'd127);
        send_random(60, 30);

        write_step(7'd1);
        tx_idle_pct = 84;
        send_random(60, 30);

        // zero step keeps channels slewing forever
        write_step(7'd0);
        tx_idle_pct  = 0;
        rx_stall_pct = 84;
        send_random(40, 30);

        // long receiver hold-off while the sender keeps pushing ticks
        write_step(7'($urandom_range(1, 127)));
        rx_stall_pct = 0;
        hold_left    = 400;
        send_random(30, 80);
        drain_reports();

        write_step(7'($urandom_range(1, 127)));
        tx_idle_pct  = 14;
        rx_stall_pct = 14;
        send_random(110, 30);

        drain_reports();
        repeat (CHANNELS + 10) @(posedge aclk);
        if (predictor.errors == 0 && predictor.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/slr_pkg.sv
rtl/slr_step_unit.sv
rtl/multichannel_motor_slew_limiter.sv
sim/multichannel_motor_slew_limiter_test.sv
